// File: rtl/obp_pkg.sv
// ----------------------------------------------------------------------------
// obp_pkg
// Shared types and constants for the object header parser: parse phases,
// result kinds, status codes, keyword table and the per-beat state record.
// ----------------------------------------------------------------------------
package obp_pkg;

    typedef enum logic [2:0] {
        PH_KEYWORD = 3'd0,
        PH_SIZE    = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_TRAIL   = 3'd3,
        PH_ERROR   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_TRAIL   = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_BAD_TYPE = 3'd1,
        STAT_BAD_SIZE = 3'd2,
        STAT_OVERFLOW = 3'd3,
        STAT_NO_NUL   = 3'd4,
        STAT_TRUNC    = 3'd5
    } status_t;

    localparam int NUM_KW = 4;
    localparam logic [2:0] KW_POS_MAX = 3'd7;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Keyword text, zero padded to eight positions: commit, blob, tree, tag.
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{8'h63, 8'h6f, 8'h6d, 8'h6d, 8'h69, 8'h74, 8'h00, 8'h00},
        '{8'h62, 8'h6c, 8'h6f, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h74, 8'h72, 8'h65, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h74, 8'h61, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd6, 3'd4, 3'd4, 3'd3};

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  kw_pos;
        logic [3:0]  kw_cand;
        logic [1:0]  type_code;
        logic        digit_seen;
        status_t     err;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:      PH_KEYWORD,
        kw_pos:     3'd0,
        kw_cand:    4'hf,
        type_code:  2'd0,
        digit_seen: 1'b0,
        err:        STAT_OK
    };

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  pdata;
        logic [1:0]  otype;
        logic [31:0] size;
        logic        finished;
        status_t     status;
    } res_t;

endpackage

// File: rtl/obp_step.sv
// ----------------------------------------------------------------------------
// obp_step
// Combinational per-beat update: keyword match, decimal size accumulation
// with overflow check, payload countdown and end-of-buffer verdict.
// ----------------------------------------------------------------------------
module obp_step #(
    parameter int LEN_WIDTH = 32
) (
    input  obp_pkg::state_t        st,
    input  logic [LEN_WIDTH-1:0]   acc,
    input  logic [LEN_WIDTH-1:0]   rem,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output obp_pkg::state_t        st_next,
    output logic [LEN_WIDTH-1:0]   acc_next,
    output logic [LEN_WIDTH-1:0]   rem_next,
    output obp_pkg::res_t          res
);

    logic                 is_digit;
    logic [3:0]           digit;
    logic [LEN_WIDTH+3:0] acc_x10;
    logic                 ovf;
    logic [LEN_WIDTH-1:0] rem_dec;
    logic                 hit;
    logic [1:0]           hit_idx;
    logic [3:0]           cand_upd;
    obp_pkg::state_t      st_upd;
    logic [LEN_WIDTH-1:0] acc_upd;
    logic [LEN_WIDTH-1:0] rem_upd;
    obp_pkg::kind_t       kind;

    assign is_digit = (data_byte >= obp_pkg::CHAR_ZERO) && (data_byte <= obp_pkg::CHAR_NINE);
    assign digit    = 4'(data_byte - obp_pkg::CHAR_ZERO);
    // acc*10 + d as shift-add; any bit at LEN_WIDTH or above means overflow
    assign acc_x10  = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (LEN_WIDTH+4)'(digit);
    assign ovf      = |acc_x10[LEN_WIDTH+3:LEN_WIDTH];
    assign rem_dec  = rem - LEN_WIDTH'(1);

    // first live candidate whose length equals the bytes seen
    always_comb begin
        hit     = 1'b0;
        hit_idx = 2'd0;
        for (int i = obp_pkg::NUM_KW - 1; i >= 0; i--) begin
            if (st.kw_cand[i] && (obp_pkg::KW_LEN[i] == st.kw_pos)) begin
                hit     = 1'b1;
                hit_idx = 2'(i);
            end
        end
    end

    always_comb begin
        cand_upd = st.kw_cand;
        for (int i = 0; i < obp_pkg::NUM_KW; i++) begin
            if ((st.kw_pos >= obp_pkg::KW_LEN[i]) ||
                (obp_pkg::KW_TEXT[i][st.kw_pos] != data_byte)) begin
                cand_upd[i] = 1'b0;
            end
        end
    end

    always_comb begin
        st_upd  = st;
        acc_upd = acc;
        rem_upd = rem;
        kind    = obp_pkg::KIND_HEADER;

        unique case (st.phase)
            obp_pkg::PH_KEYWORD: begin
                if (data_byte == obp_pkg::CHAR_SPACE) begin
                    if (hit) begin
                        st_upd.type_code = hit_idx;
                        st_upd.phase     = obp_pkg::PH_SIZE;
                    end else begin
                        st_upd.phase = obp_pkg::PH_ERROR;
                        st_upd.err   = obp_pkg::STAT_BAD_TYPE;
                        kind         = obp_pkg::KIND_ERROR;
                    end
                end else begin
                    st_upd.kw_cand = cand_upd;
                    if (st.kw_pos != obp_pkg::KW_POS_MAX) begin
                        st_upd.kw_pos = st.kw_pos + 3'd1;
                    end
                    if (cand_upd == 4'd0) begin
                        st_upd.phase = obp_pkg::PH_ERROR;
                        st_upd.err   = obp_pkg::STAT_BAD_TYPE;
                        kind         = obp_pkg::KIND_ERROR;
                    end
                end
            end
            obp_pkg::PH_SIZE: begin
                if (is_digit) begin
                    if (ovf) begin
                        st_upd.phase = obp_pkg::PH_ERROR;
                        st_upd.err   = obp_pkg::STAT_OVERFLOW;
                        kind         = obp_pkg::KIND_ERROR;
                    end else begin
                        acc_upd           = acc_x10[LEN_WIDTH-1:0];
                        st_upd.digit_seen = 1'b1;
                    end
                end else if (data_byte == obp_pkg::CHAR_NUL) begin
                    if (!st.digit_seen) begin
                        st_upd.phase = obp_pkg::PH_ERROR;
                        st_upd.err   = obp_pkg::STAT_BAD_SIZE;
                        kind         = obp_pkg::KIND_ERROR;
                    end else begin
                        rem_upd      = acc;
                        st_upd.phase = (acc != '0) ? obp_pkg::PH_PAYLOAD : obp_pkg::PH_TRAIL;
                    end
                end else begin
                    st_upd.phase = obp_pkg::PH_ERROR;
                    st_upd.err   = obp_pkg::STAT_BAD_SIZE;
                    kind         = obp_pkg::KIND_ERROR;
                end
            end
            obp_pkg::PH_PAYLOAD: begin
                kind    = obp_pkg::KIND_PAYLOAD;
                rem_upd = rem_dec;
                if (rem_dec == '0) begin
                    st_upd.phase = obp_pkg::PH_TRAIL;
                end
            end
            obp_pkg::PH_TRAIL: begin
                kind = obp_pkg::KIND_TRAIL;
            end
            default: begin
                kind = obp_pkg::KIND_ERROR;
            end
        endcase

        // end of buffer: unfinished phases turn into their error
        if (last_byte) begin
            priority case (st_upd.phase)
                obp_pkg::PH_KEYWORD: st_upd.err = obp_pkg::STAT_BAD_TYPE;
                obp_pkg::PH_SIZE:    st_upd.err = obp_pkg::STAT_NO_NUL;
                obp_pkg::PH_PAYLOAD: st_upd.err = obp_pkg::STAT_TRUNC;
                default:             st_upd.err = st_upd.err;
            endcase
        end

        res.kind     = kind;
        res.pdata    = (kind == obp_pkg::KIND_PAYLOAD) ? data_byte : 8'd0;
        res.otype    = st_upd.type_code;
        res.size     = 32'(acc_upd);
        res.finished = last_byte;
        res.status   = last_byte ? st_upd.err : obp_pkg::STAT_OK;

        if (last_byte) begin
            st_next  = obp_pkg::STATE_RESET;
            acc_next = '0;
            rem_next = '0;
        end else begin
            st_next  = st_upd;
            acc_next = acc_upd;
            rem_next = rem_upd;
        end
    end

endmodule

// File: rtl/object_header_parser_core.sv
// ----------------------------------------------------------------------------
// object_header_parser_core
// Parses "<type> <size>\0<payload>" one byte per beat and tags every byte.
// ----------------------------------------------------------------------------
// Result: registered result stage; an accepted beat's result is shown in the cycle after it.
// Throughput: 1 beat per cycle while the result is not stalled; the parse
//   state update is a single shift-add plus compare, done combinationally.
// Reset: aresetn (sync, active low) returns the parser to the keyword phase
//   and empties the result register. State also self-resets after the
//   beat flagged last.
module object_header_parser_core #(
    parameter int LEN_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_payload_data,
    output logic [1:0]  m_object_type,
    output logic [31:0] m_payload_size,
    output logic        m_finished,
    output logic [2:0]  m_status
);

    // parse state
    obp_pkg::state_t       st_reg,  st_next;
    logic [LEN_WIDTH-1:0]  acc_reg, acc_next;
    logic [LEN_WIDTH-1:0]  rem_reg, rem_next;

    // result register
    obp_pkg::res_t         res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;

    logic                  s_fire;

    // Result stage frees up when empty or being drained this cycle, so a
    // new beat goes in while the previous result is taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    obp_step #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_step (
        .st        (st_reg),
        .acc       (acc_reg),
        .rem       (rem_reg),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .st_next   (st_next),
        .acc_next  (acc_next),
        .rem_next  (rem_next),
        .res       (res_next)
    );

    always_comb begin
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state: parse state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= obp_pkg::STATE_RESET;
            acc_reg     <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                st_reg  <= st_next;
                acc_reg <= acc_next;
                rem_reg <= rem_next;
            end
        end
    end

    // result payload, loaded on each accepted beat
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = res_reg.kind;
    assign m_payload_data = res_reg.pdata;
    assign m_object_type  = res_reg.otype;
    assign m_payload_size = res_reg.size;
    assign m_finished     = res_reg.finished;
    assign m_status       = res_reg.status;

endmodule

// File: rtl/obp_checker.sv
// ----------------------------------------------------------------------------
// obp_checker
// Port-level checks on the parser core, bound into the core module.
// ----------------------------------------------------------------------------
module obp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [7:0] m_payload_data,
    input logic       m_finished,
    input logic [2:0] m_status
);

    // input only backs up when a result is stuck
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a stalled result");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_kind) &&
                                   $stable(m_payload_data) && $stable(m_status)))
        else $error("stalled result changed");

    // verdict only on the final beat
    a_status_only_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_finished) |-> (m_status == obp_pkg::STAT_OK))
        else $error("nonzero status on a non-final beat");

    // data lane quiet outside payload
    a_pdata_only_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind != obp_pkg::KIND_PAYLOAD)) |-> (m_payload_data == 8'd0))
        else $error("payload data on non-payload beat");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_finished) |-> (m_status <= obp_pkg::STAT_TRUNC))
        else $error("status code out of range");

endmodule

bind object_header_parser_core obp_checker u_obp_checker (.*);
